### rtl/rba_pkg.sv
// shared types and constants of the region block allocator
`default_nettype none

package rba_pkg;

  localparam int ADDR_WIDTH = 48;
  localparam int SHIFT_W    = 5;
  localparam int COUNT_W    = 9;
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;

  typedef logic [CMD_W-1:0]     cmd_t;
  typedef logic [STATUS_W-1:0]  status_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cmd_t CMD_ALLOC_SINGLE = 2'd0;
  localparam cmd_t CMD_ALLOC_RUN    = 2'd1;
  localparam cmd_t CMD_FREE         = 2'd2;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_NOSPACE = 2'd1;
  localparam status_t ST_BAD     = 2'd2;

  localparam cfg_idx_t CFG_BASE_ADDRESS   = 2'd0;
  localparam cfg_idx_t CFG_REGION_SHIFT   = 2'd1;
  localparam cfg_idx_t CFG_ACTIVE_REGIONS = 2'd2;

  localparam logic [SHIFT_W-1:0] REGION_SHIFT_RESET = 5'd18;

  typedef struct packed {
    cmd_t                  command;
    logic [ADDR_WIDTH-1:0] byte_size;
    logic [ADDR_WIDTH-1:0] region_address;
  } req_t;

  typedef struct packed {
    status_t               status;
    logic [ADDR_WIDTH-1:0] result_address;
    logic [COUNT_W-1:0]    used_count;
  } resp_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_PREP,
    S_CHECK,
    S_FREE_IDX,
    S_SCAN,
    S_MARK,
    S_ADDR,
    S_DONE
  } rba_state_t;

endpackage

`default_nettype wire

### rtl/rba_owner_ram.sv
// owner map storage: one write port, one registered read port
`default_nettype none

module rba_owner_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 9
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### rtl/region_block_allocator_unit.sv
// region block allocator: first-fit run allocation and checked release over an owner map
// sequence: alloc walks the active range until a free run of n is found, then does n marking
//   writes; free reads the ownership of the n regions, then does n clearing writes
// throughput: one request at a time, ready again in the cycle the result is posted; a stalled
//   result holds the sequencer; the owner map does one read or one write a cycle
// reset: synchronous, active high; then a clearing pass over all MAX_REGIONS entries with req_ready low
`default_nettype none

module region_block_allocator_unit #(
  parameter int MAX_REGIONS = 256
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // configuration write port
  input  wire logic                              cfg_we,
  input  wire logic [rba_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [rba_pkg::ADDR_WIDTH-1:0]    cfg_data,
  // request channel
  input  wire logic                              req_valid,
  output logic                                   req_ready,
  input  wire rba_pkg::req_t                     req,
  // result channel
  output logic                                   resp_valid,
  input  wire logic                              resp_ready,
  output rba_pkg::resp_t                         resp
);

  localparam int IW    = $clog2(MAX_REGIONS);      // region index bits
  localparam int CW    = $clog2(MAX_REGIONS + 1);  // region count bits, also owner entry bits
  localparam int AW    = rba_pkg::ADDR_WIDTH;
  localparam int SW    = rba_pkg::SHIFT_W;
  localparam int UW    = rba_pkg::COUNT_W;
  localparam int CMP_W = (CW > UW) ? CW : UW;

  // configuration registers
  logic [AW-1:0] base_address;
  logic [SW-1:0] region_shift;
  logic [UW-1:0] active_regions;

  // sequencer
  rba_pkg::rba_state_t state, state_next;

  // captured request
  rba_pkg::cmd_t req_cmd;
  logic [AW-1:0] req_size;
  logic [AW-1:0] req_addr;

  // derived operands
  logic [CW-1:0] n;          // region count of the request
  logic          n_zero;
  logic          n_big;      // count exceeds the active regions
  logic [AW-1:0] offset;     // free address minus base
  logic          below;      // free address below the block
  logic          aligned;
  logic          idx_big;

  // walker
  logic [CW-1:0] left;       // start of the candidate run, or run to free
  logic [CW-1:0] run;        // free entries seen since left
  logic [CW-1:0] issue_ptr;
  logic [CW-1:0] eval_ptr;
  logic          rd_pend;
  logic [CW-1:0] scan_end;
  logic [CW-1:0] mark_ptr;   // also the clearing pointer after reset
  logic [CW-1:0] mark_end;

  logic [CW-1:0]           regions_used;
  rba_pkg::status_t        status_r;
  logic [AW-1:0]           res_r;

  // owner map port
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [CW-1:0] wr_data;
  logic [IW-1:0] rd_addr;
  logic [CW-1:0] rd_data;

  // combinational helpers
  logic [CMP_W-1:0] act_ext;
  logic [CMP_W-1:0] max_ext;
  logic [CW-1:0]    act;
  logic [AW-1:0]    n_full;
  logic [AW-1:0]    idx_full;
  logic [AW-1:0]    low_mask;
  logic             is_alloc;
  logic             scan_hit;
  logic             scan_last;
  logic             own_bad;
  logic             mark_last;
  logic             clear_last;
  logic             free_fail;
  logic             slot_free;

  rba_owner_ram #(
    .DEPTH (MAX_REGIONS),
    .WIDTH (CW)
  ) u_owner_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // active count clamped to the map size
  assign act_ext = CMP_W'(active_regions);
  assign max_ext = CMP_W'(MAX_REGIONS);
  assign act     = CW'((act_ext > max_ext) ? max_ext : act_ext);

  // byte size to region count, address offset to region index
  assign n_full   = req_size >> region_shift;
  assign idx_full = offset >> region_shift;
  assign low_mask = ~({AW{1'b1}} << region_shift);

  assign is_alloc = (req_cmd == rba_pkg::CMD_ALLOC_SINGLE) ||
                    (req_cmd == rba_pkg::CMD_ALLOC_RUN);

  // walk evaluation on the entry read in the previous cycle
  assign scan_hit   = rd_pend && (rd_data == '0) && ((run + CW'(1)) == n);
  assign scan_last  = rd_pend && ((eval_ptr + CW'(1)) == scan_end);
  assign own_bad    = rd_pend && (rd_data != (left + CW'(1)));
  assign mark_last  = (mark_ptr + CW'(1)) == mark_end;
  assign clear_last = mark_ptr == CW'(MAX_REGIONS - 1);
  assign free_fail  = !aligned || idx_big || n_big || (n > (act - left));
  assign slot_free  = !resp_valid || resp_ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      rba_pkg::S_CLEAR: begin
        if (clear_last) state_next = rba_pkg::S_IDLE;
      end
      rba_pkg::S_IDLE: begin
        if (req_valid) state_next = rba_pkg::S_PREP;
      end
      rba_pkg::S_PREP: begin
        state_next = rba_pkg::S_CHECK;
      end
      rba_pkg::S_CHECK: begin
        if (is_alloc) begin
          state_next = (n_zero || n_big) ? rba_pkg::S_DONE : rba_pkg::S_SCAN;
        end else if (req_cmd == rba_pkg::CMD_FREE) begin
          state_next = (n_zero || below) ? rba_pkg::S_DONE : rba_pkg::S_FREE_IDX;
        end else begin
          state_next = rba_pkg::S_DONE;
        end
      end
      rba_pkg::S_FREE_IDX: begin
        state_next = free_fail ? rba_pkg::S_DONE : rba_pkg::S_SCAN;
      end
      rba_pkg::S_SCAN: begin
        if (is_alloc) begin
          if (scan_hit) state_next = rba_pkg::S_MARK;
          else if (scan_last) state_next = rba_pkg::S_DONE;
        end else begin
          if (own_bad) state_next = rba_pkg::S_DONE;
          else if (scan_last) state_next = rba_pkg::S_MARK;
        end
      end
      rba_pkg::S_MARK: begin
        if (mark_last) state_next = is_alloc ? rba_pkg::S_ADDR : rba_pkg::S_DONE;
      end
      rba_pkg::S_ADDR: begin
        state_next = rba_pkg::S_DONE;
      end
      rba_pkg::S_DONE: begin
        if (slot_free) state_next = rba_pkg::S_IDLE;
      end
      default: begin
        state_next = rba_pkg::S_IDLE;
      end
    endcase
  end

  // handshake and owner map port
  always_comb begin
    req_ready = (state == rba_pkg::S_IDLE);
    wr_en     = (state == rba_pkg::S_CLEAR) || (state == rba_pkg::S_MARK);
    wr_addr   = mark_ptr[IW-1:0];
    // alloc tags each region with its run start plus one, free and clear write zero
    wr_data   = ((state == rba_pkg::S_MARK) && is_alloc) ? (left + CW'(1)) : '0;
    rd_addr   = issue_ptr[IW-1:0];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address   <= '0;
      region_shift   <= rba_pkg::REGION_SHIFT_RESET;
      active_regions <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rba_pkg::CFG_BASE_ADDRESS:   base_address   <= cfg_data;
        rba_pkg::CFG_REGION_SHIFT:   region_shift   <= cfg_data[SW-1:0];
        rba_pkg::CFG_ACTIVE_REGIONS: active_regions <= cfg_data[UW-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and walker registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= rba_pkg::S_CLEAR;
      mark_ptr     <= '0;
      regions_used <= '0;
      resp_valid   <= 1'b0;
      rd_pend      <= 1'b0;
    end else begin
      state <= state_next;

      // result register: taken by the consumer, or refilled from the sequencer
      if ((state == rba_pkg::S_DONE) && slot_free) begin
        resp_valid          <= 1'b1;
        resp.status         <= status_r;
        resp.result_address <= res_r;
        resp.used_count     <= UW'(regions_used);
      end else if (resp_ready) begin
        resp_valid <= 1'b0;
      end

      case (state)
        rba_pkg::S_CLEAR: begin
          mark_ptr <= mark_ptr + CW'(1);
        end
        rba_pkg::S_IDLE: begin
          if (req_valid) begin
            req_cmd  <= req.command;
            req_size <= req.byte_size;
            req_addr <= req.region_address;
          end
        end
        rba_pkg::S_PREP: begin
          status_r <= rba_pkg::ST_BAD;
          res_r    <= '0;
          if (req_cmd == rba_pkg::CMD_ALLOC_SINGLE) begin
            // a single region is a run of one
            n      <= CW'(1);
            n_zero <= 1'b0;
            n_big  <= (act == '0);
          end else begin
            n      <= CW'(n_full);
            n_zero <= (n_full == '0);
            n_big  <= (n_full > AW'(act));
          end
          offset <= req_addr - base_address;
          below  <= (req_addr < base_address);
        end
        rba_pkg::S_CHECK: begin
          if (is_alloc && !n_zero && n_big) status_r <= rba_pkg::ST_NOSPACE;
          aligned   <= ((offset & low_mask) == '0);
          idx_big   <= (idx_full >= AW'(act));
          // alloc walks the whole active range from region zero
          left      <= is_alloc ? '0 : CW'(idx_full);
          run       <= '0;
          issue_ptr <= '0;
          scan_end  <= act;
          rd_pend   <= 1'b0;
        end
        rba_pkg::S_FREE_IDX: begin
          issue_ptr <= left;
          scan_end  <= left + n;
          rd_pend   <= 1'b0;
        end
        rba_pkg::S_SCAN: begin
          // one read issued per cycle, data checked in the cycle after
          rd_pend   <= (issue_ptr < scan_end);
          eval_ptr  <= issue_ptr;
          issue_ptr <= issue_ptr + CW'(1);
          if (is_alloc) begin
            if (rd_pend) begin
              if (rd_data != '0) begin
                // blocked: restart the candidate just past this entry
                left <= eval_ptr + CW'(1);
                run  <= '0;
              end else begin
                run <= run + CW'(1);
              end
            end
            if (!scan_hit && scan_last) status_r <= rba_pkg::ST_NOSPACE;
          end
          mark_ptr <= left;
          mark_end <= left + n;
        end
        rba_pkg::S_MARK: begin
          mark_ptr <= mark_ptr + CW'(1);
          if (mark_last) begin
            if (is_alloc) begin
              regions_used <= regions_used + n;
            end else begin
              regions_used <= regions_used - n;
              status_r     <= rba_pkg::ST_OK;
            end
          end
        end
        rba_pkg::S_ADDR: begin
          status_r <= rba_pkg::ST_OK;
          res_r    <= base_address + (AW'(left) << region_shift);
        end
        rba_pkg::S_DONE: begin
          rd_pend <= 1'b0;
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/rba_checker.sv
// port-level checks of the region block allocator and their binding
`default_nettype none

module rba_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           req_valid,
  input wire logic           req_ready,
  input wire logic           resp_valid,
  input wire logic           resp_ready,
  input wire rba_pkg::resp_t resp
);

  // a held result keeps its payload
  a_resp_hold: assert property (@(posedge clk) disable iff (rst)
    resp_valid && !resp_ready |=> resp_valid && $stable(resp))
    else $error("result changed while stalled");

  // refused or failed requests report no address
  a_no_addr_on_fail: assert property (@(posedge clk) disable iff (rst)
    resp_valid && (resp.status != rba_pkg::ST_OK) |-> resp.result_address == '0)
    else $error("address reported on a failed request");

  // a request keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  // reset starts the clearing pass with no result pending
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !req_ready && !resp_valid)
    else $error("ready or result right after reset");

endmodule

bind region_block_allocator_unit rba_checker u_rba_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req_valid),
  .req_ready  (req_ready),
  .resp_valid (resp_valid),
  .resp_ready (resp_ready),
  .resp       (resp)
);

`default_nettype wire

### tb/tb.sv
// self-checking testbench for the region block allocator unit
module tb;

  localparam int          REGION_SLOTS = 256;
  localparam int          QUIET_LIMIT  = 5000;
  localparam int          DRAIN_CYCLES = 600;
  // command code 3 has no meaning in the block
  localparam rba_pkg::cmd_t CMD_UNDEFINED = 2'd3;
  // directed layout: 4 KiB regions at an odd base
  localparam logic [47:0] DIR_BASE   = 48'h0000_1234_5000;
  localparam logic [4:0]  DIR_SHIFT  = 5'd12;
  localparam logic [47:0] DIR_REGION = 48'h1000;
  localparam logic [47:0] ALL_ONES   = 48'hFFFF_FFFF_FFFF;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  rba_pkg::cfg_idx_t cfg_index = rba_pkg::CFG_BASE_ADDRESS;
  logic [47:0]       cfg_data = '0;
  logic              req_valid = 1'b0;
  logic              req_ready;
  rba_pkg::req_t     req_payload = '0;
  logic              resp_valid;
  logic              resp_ready = 1'b0;
  rba_pkg::resp_t    resp_payload;

  region_block_allocator_unit #(
    .MAX_REGIONS(REGION_SLOTS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req_payload),
    .resp_valid(resp_valid),
    .resp_ready(resp_ready),
    .resp      (resp_payload)
  );

  always #5 clk = ~clk;

  // shadow of the block: owner map, use count and registers
  logic [8:0]  owner_map [REGION_SLOTS];
  logic [8:0]  used_regions;
  logic [47:0] cfg_base;
  logic [4:0]  cfg_shift;
  logic [8:0]  cfg_active;

  rba_pkg::req_t  queued_requests[$];
  rba_pkg::resp_t awaited_replies[$];
  rba_pkg::resp_t oldest_reply;
  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;
  int          mismatch_count = 0;
  int          quiet_cycles = 0;

  // address of region k, wrapping at 48 bits
  function automatic logic [47:0] region_base(logic [63:0] k);
    return 48'(64'(cfg_base) + (k << cfg_shift));
  endfunction

  // effective active count, clamped to the map size
  function automatic logic [63:0] usable_regions();
    return (cfg_active > REGION_SLOTS) ? 64'(REGION_SLOTS) : 64'(cfg_active);
  endfunction

  // applies one request to the shadow map and returns the reply it must give
  function automatic rba_pkg::resp_t allocator_reply(rba_pkg::req_t r);
    rba_pkg::resp_t reply;
    logic [63:0]    act, n, left, right, idx, off, k;
    bit             found, ok;
    reply.status         = rba_pkg::ST_BAD;
    reply.result_address = '0;
    act   = usable_regions();
    n     = 64'(r.byte_size) >> cfg_shift;
    found = 1'b0;
    case (r.command)
      rba_pkg::CMD_ALLOC_SINGLE: begin
        reply.status = rba_pkg::ST_NOSPACE;
        for (k = 0; k < act && !found; k++) begin
          if (owner_map[k] == 0) begin
            owner_map[k]         = 9'(k + 1);
            used_regions         = used_regions + 9'd1;
            reply.status         = rba_pkg::ST_OK;
            reply.result_address = region_base(k);
            found                = 1'b1;
          end
        end
      end
      rba_pkg::CMD_ALLOC_RUN: begin
        // zero-length run is refused outright
        if (n != 0) begin
          reply.status = rba_pkg::ST_NOSPACE;
          left = 0;
          // first fit: on a blocked window jump past the blocking entry
          while (!found && n <= act && left <= act - n) begin
            right = left;
            ok    = 1'b1;
            while (ok && right < left + n) begin
              if (owner_map[right] != 0) ok = 1'b0;
              else right++;
            end
            if (ok) begin
              for (k = left; k < left + n; k++) owner_map[k] = 9'(left + 1);
              used_regions         = used_regions + 9'(n);
              reply.status         = rba_pkg::ST_OK;
              reply.result_address = region_base(left);
              found                = 1'b1;
            end else begin
              left = right + 1;
            end
          end
        end
      end
      rba_pkg::CMD_FREE: begin
        ok  = (n != 0) && (r.region_address >= cfg_base);
        idx = 0;
        if (ok) begin
          off = 64'(r.region_address - cfg_base);
          idx = off >> cfg_shift;
          if ((off & ((64'd1 << cfg_shift) - 1)) != 0 || idx >= act || n > act - idx)
            ok = 1'b0;
        end
        // every region of the run must belong to the run starting at idx
        for (k = idx; ok && k < idx + n; k++) begin
          if (owner_map[k] != idx + 1) ok = 1'b0;
        end
        if (ok) begin
          for (k = idx; k < idx + n; k++) owner_map[k] = '0;
          used_regions = used_regions - 9'(n);
          reply.status = rba_pkg::ST_OK;
        end
      end
      default: begin
        reply.status = rba_pkg::ST_BAD;
      end
    endcase
    reply.used_count = used_regions;
    return reply;
  endfunction

  function automatic void enqueue(rba_pkg::cmd_t cmd, logic [47:0] size, logic [47:0] addr);
    rba_pkg::req_t item;
    item.command        = cmd;
    item.byte_size      = size;
    item.region_address = addr;
    queued_requests     = {queued_requests, item};
  endfunction

  // mostly well-formed traffic drawn from the current shadow map, some noise
  function automatic rba_pkg::req_t random_request();
    rba_pkg::req_t item;
    int unsigned   roll;
    logic [63:0]   act, n, start, span, k, probe;
    bit            found;
    act                 = usable_regions();
    roll                = $urandom_range(99);
    item.command        = rba_pkg::CMD_ALLOC_RUN;
    item.byte_size      = 48'({$urandom, $urandom});
    item.region_address = 48'({$urandom, $urandom});
    found = 1'b0;
    start = 0;
    span  = 0;
    // look for a live run to release, starting at a random spot
    if (roll >= 60 && roll < 90 && act != 0) begin
      probe = 64'($urandom_range(32'(act - 1)));
      for (k = 0; k < act && !found; k++) begin
        if (owner_map[(probe + k) % act] != 0) begin
          found = 1'b1;
          start = 64'(owner_map[(probe + k) % act]) - 64'd1;
        end
      end
      while (start + span < act && owner_map[start + span] == start + 1) span++;
    end
    if (roll < 25) begin
      item.command = rba_pkg::CMD_ALLOC_SINGLE;
    end else if (roll < 60 || (roll < 90 && !found)) begin
      // short runs mostly, now and then one up to the block length plus one
      n = ($urandom_range(9) == 0) ? 64'($urandom_range(32'(act + 1), 1))
                                   : 64'($urandom_range(6, 1));
      if ($urandom_range(3) == 0)
        item.byte_size = 48'((n << cfg_shift) +
                             (64'(item.byte_size) & ((64'd1 << cfg_shift) - 1)));
      else
        item.byte_size = 48'(n << cfg_shift);
    end else if (roll < 90) begin
      item.command = rba_pkg::CMD_FREE;
      // head already released: aim at the orphaned tail
      if (span == 0)
        n = 64'd1;
      else if ($urandom_range(3) == 0)
        n = 64'($urandom_range(32'(span), 1));
      else
        n = span;
      item.byte_size      = 48'(n << cfg_shift);
      item.region_address = region_base(start);
    end else begin
      item.command = rba_pkg::cmd_t'($urandom_range(3));
      if ($urandom_range(1) == 1) begin
        item.region_address = region_base(64'($urandom_range(32'(act))));
        item.byte_size      = 48'(64'($urandom_range(4, 1)) << cfg_shift);
      end
    end
    return item;
  endfunction

  // three register writes on back-to-back edges, shadow follows
  task automatic program_block(input logic [47:0] base, input logic [4:0] shift,
                               input logic [8:0] count);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= rba_pkg::CFG_BASE_ADDRESS;
    cfg_data  <= base;
    @(posedge clk);
    cfg_index <= rba_pkg::CFG_REGION_SHIFT;
    cfg_data  <= {43'd0, shift};
    @(posedge clk);
    cfg_index <= rba_pkg::CFG_ACTIVE_REGIONS;
    cfg_data  <= {39'd0, count};
    @(posedge clk);
    cfg_we     <= 1'b0;
    cfg_base   = base;
    cfg_shift  = shift;
    cfg_active = count;
  endtask

  // wait until every request is in and every reply is out
  task automatic settle();
    while (queued_requests.size() != 0 || req_valid || awaited_replies.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_random(input int count);
    repeat (count) begin
      while (queued_requests.size() >= 2) @(negedge clk);
      queued_requests = {queued_requests, random_request()};
    end
  endtask

  task automatic report_field(input string field, input logic [47:0] want,
                              input logic [47:0] got);
    $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    mismatch_count++;
  endtask

  // request driver: holds valid and payload until taken, predicts on acceptance
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready)
        awaited_replies = {awaited_replies, allocator_reply(req_payload)};
      if (!req_valid || req_ready) begin
        if (queued_requests.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          req_payload <= queued_requests.pop_front();
          req_valid   <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // reply side back-pressure
  always @(posedge clk) begin
    resp_ready <= rst ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
  end

  // reply monitor: in-order compare against the oldest prediction
  always @(posedge clk) begin
    if (!rst && resp_valid && resp_ready) begin
      if (awaited_replies.size() == 0) begin
        $display("%0t: reply with none awaited, status %h address %h used %h",
                 $time, resp_payload.status, resp_payload.result_address,
                 resp_payload.used_count);
        mismatch_count++;
      end else begin
        oldest_reply = awaited_replies.pop_front();
        if (resp_payload.status !== oldest_reply.status)
          report_field("status", 48'(oldest_reply.status), 48'(resp_payload.status));
        if (resp_payload.result_address !== oldest_reply.result_address)
          report_field("result_address", oldest_reply.result_address,
                       resp_payload.result_address);
        if (resp_payload.used_count !== oldest_reply.used_count)
          report_field("used_count", 48'(oldest_reply.used_count),
                       48'(resp_payload.used_count));
      end
    end
  end

  // watchdog: too long without any handshake or register write
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (resp_valid && resp_ready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("region_block_allocator_unit regression: fail");
      $finish;
    end
  end

  initial begin
    foreach (owner_map[i]) owner_map[i] = '0;
    used_regions   = '0;
    cfg_base       = '0;
    cfg_shift      = rba_pkg::REGION_SHIFT_RESET;
    cfg_active     = '0;
    send_gap_pct   = 34;
    recv_stall_pct = 58;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: 16 regions of 4 KiB, written during the clearing pass
    program_block(DIR_BASE, DIR_SHIFT, 9'd16);
    enqueue(rba_pkg::CMD_ALLOC_SINGLE, '0, '0);
    enqueue(rba_pkg::CMD_ALLOC_SINGLE, ALL_ONES, ALL_ONES);
    enqueue(rba_pkg::CMD_ALLOC_RUN, 3 * DIR_REGION, '0);
    // remainder below one region is dropped
    enqueue(rba_pkg::CMD_ALLOC_RUN, 2 * DIR_REGION + 5, '0);
    // under one region is a zero-length run
    enqueue(rba_pkg::CMD_ALLOC_RUN, DIR_REGION - 1, '0);
    // longer than the block
    enqueue(rba_pkg::CMD_ALLOC_RUN, 17 * DIR_REGION, '0);
    enqueue(rba_pkg::CMD_ALLOC_RUN, ALL_ONES, ALL_ONES);
    // partial free from the head, tail stays owned
    enqueue(rba_pkg::CMD_FREE, DIR_REGION, DIR_BASE + 2 * DIR_REGION);
    // tail is owned by another start: ownership mismatch
    enqueue(rba_pkg::CMD_FREE, 2 * DIR_REGION, DIR_BASE + 3 * DIR_REGION);
    // below the block, misaligned, past the active end, zero length
    enqueue(rba_pkg::CMD_FREE, DIR_REGION, DIR_BASE - DIR_REGION);
    enqueue(rba_pkg::CMD_FREE, DIR_REGION, DIR_BASE + 48'h800);
    enqueue(rba_pkg::CMD_FREE, 2 * DIR_REGION, DIR_BASE + 15 * DIR_REGION);
    enqueue(rba_pkg::CMD_FREE, '0, DIR_BASE);
    enqueue(rba_pkg::CMD_FREE, DIR_REGION, ALL_ONES);
    enqueue(CMD_UNDEFINED, ALL_ONES, ALL_ONES);
    enqueue(rba_pkg::CMD_FREE, DIR_REGION, DIR_BASE);
    // first fit has to skip the owned tail to find nine in a row
    enqueue(rba_pkg::CMD_ALLOC_RUN, 9 * DIR_REGION, '0);
    enqueue(rba_pkg::CMD_ALLOC_SINGLE, '0, '0);
    enqueue(rba_pkg::CMD_ALLOC_SINGLE, '0, '0);
    enqueue(rba_pkg::CMD_ALLOC_SINGLE, '0, '0);
    settle();

    // shrink the active count under live runs
    program_block(DIR_BASE, DIR_SHIFT, 9'd4);
    enqueue(rba_pkg::CMD_ALLOC_SINGLE, '0, '0);
    enqueue(rba_pkg::CMD_FREE, 9 * DIR_REGION, DIR_BASE + 7 * DIR_REGION);
    settle();

    // nothing allocatable
    program_block(DIR_BASE, DIR_SHIFT, 9'd0);
    enqueue(rba_pkg::CMD_ALLOC_SINGLE, '0, '0);
    enqueue(rba_pkg::CMD_ALLOC_RUN, DIR_REGION, '0);
    settle();

    program_block(48'({$urandom, $urandom}), 5'd12, 9'd32);
    run_random(150);
    settle();

    // swap the idle ratios
    send_gap_pct   = 58;
    recv_stall_pct = 34;
    program_block(48'hFFFF_F000_0000, 5'd20, 9'd256);
    run_random(150);
    settle();

    // count register above the map size, largest shift
    program_block('0, 5'd31, 9'd511);
    run_random(100);
    settle();

    // no idling from here on
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    program_block(48'({$urandom, $urandom}), 5'd0, 9'd8);
    run_random(100);
    settle();

    // top base: region addresses wrap past 48 bits
    program_block(ALL_ONES, 5'd30, 9'd64);
    run_random(100);
    settle();

    // let any stray reply show up
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0)
      $display("region_block_allocator_unit regression: pass");
    else
      $display("region_block_allocator_unit regression: fail");
    $finish;
  end

endmodule

### filelist.f
rtl/rba_pkg.sv
rtl/rba_owner_ram.sv
rtl/region_block_allocator_unit.sv
rtl/rba_checker.sv
tb/tb.sv
